FILE: rtl/pphm_pkg.sv
// Package with the types and constants shared by the parallel-port handshake master.
package pphm_pkg;

  // Command bytes driven at the start of a transfer
  localparam logic [7:0] CMD_SEND = 8'h11;
  localparam logic [7:0] CMD_RECV = 8'h22;

  // Register indexes (word address bit 2)
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_STOP    = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SEND = 2'd1,
    OP_RECV = 2'd2
  } opcode_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_S_CMD  = 4'd1,
    PH_S_HI   = 4'd2,
    PH_S_LO   = 4'd3,
    PH_S_DATA = 4'd4,
    PH_R_CMD  = 4'd5,
    PH_R_HI   = 4'd6,
    PH_R_LO   = 4'd7,
    PH_R_DATA = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ACTIVE = 2'd1,
    ST_DONE   = 2'd2,
    ST_FAIL   = 2'd3
  } status_t;

  // Transfer state carried from beat to beat
  typedef struct packed {
    phase_t      phase;
    logic        pout;
    logic        sel;
    logic        drive;
    logic [7:0]  pin;
    logic [15:0] byte_count;
    logic [15:0] xfer_len;
    logic [15:0] wait_count;
    status_t     last_status;
    logic        rx_mode;
  } xfer_state_t;

  // One result beat
  typedef struct packed {
    logic [7:0]  data_out;
    logic        data_drive;
    logic        sel_out;
    logic        pout_out;
    logic [7:0]  rx_byte;
    logic        rx_valid;
    logic        rx_last;
    logic        tx_take;
    logic [15:0] recv_length;
    status_t     status;
  } result_t;

endpackage

FILE: rtl/pphm_step.sv
// Next-state and result logic for one sampling tick of the handshake master.
module pphm_step (
  input  pphm_pkg::xfer_state_t cur,
  input  logic [1:0]            opcode,
  input  logic [15:0]           length,
  input  logic [7:0]            tx_byte,
  input  logic                  busy_in,
  input  logic [7:0]            data_in,
  input  logic [15:0]           timeout_ticks,
  input  logic                  send_stops_on_timeout,
  output pphm_pkg::xfer_state_t nxt,
  output pphm_pkg::result_t     res
);
  import pphm_pkg::*;

  logic        met;
  logic        fin;
  status_t     fin_st;
  logic [15:0] wait_inc;
  logic [15:0] count_inc;
  logic [15:0] rx_len;

  assign wait_inc  = cur.wait_count + 16'd1;
  assign count_inc = cur.byte_count + 16'd1;
  assign rx_len    = {cur.xfer_len[15:8], data_in};

  // Advance the transfer by one tick
  always_comb begin
    nxt          = cur;
    met          = 1'b0;
    fin          = 1'b0;
    fin_st       = ST_IDLE;
    res.rx_byte  = 8'd0;
    res.rx_valid = 1'b0;
    res.rx_last  = 1'b0;
    res.tx_take  = 1'b0;

    if (cur.phase == PH_IDLE) begin
      if (opcode == OP_SEND || opcode == OP_RECV) begin
        nxt.rx_mode     = (opcode == OP_RECV);
        nxt.xfer_len    = (opcode == OP_RECV) ? 16'd0 : length;
        nxt.byte_count  = 16'd0;
        nxt.wait_count  = 16'd0;
        nxt.pin         = (opcode == OP_RECV) ? CMD_RECV : CMD_SEND;
        nxt.drive       = 1'b1;
        nxt.sel         = 1'b1;
        nxt.pout        = 1'b0;
        nxt.phase       = (opcode == OP_RECV) ? PH_R_CMD : PH_S_CMD;
        nxt.last_status = ST_ACTIVE;
      end
    end else begin
      // BUSY must mirror the inverse of POUT; count ticks until it does
      met = (busy_in == !cur.pout);
      if (!met) begin
        nxt.wait_count = wait_inc;
        if (wait_inc >= timeout_ticks) begin
          if (cur.rx_mode || send_stops_on_timeout) begin
            fin    = 1'b1;
            fin_st = ST_FAIL;
          end else begin
            met = 1'b1;
          end
        end
      end
      if (met && !fin) begin
        nxt.wait_count = 16'd0;
        unique case (cur.phase)
          PH_S_CMD: begin
            nxt.pin   = cur.xfer_len[15:8];
            nxt.pout  = 1'b1;
            nxt.phase = PH_S_HI;
          end
          PH_S_HI: begin
            nxt.pin   = cur.xfer_len[7:0];
            nxt.pout  = 1'b0;
            nxt.phase = PH_S_LO;
          end
          PH_S_LO: begin
            if (cur.xfer_len == 16'd0) begin
              fin    = 1'b1;
              fin_st = ST_DONE;
            end else begin
              nxt.pin        = tx_byte;
              res.tx_take    = 1'b1;
              nxt.pout       = 1'b1;
              nxt.byte_count = 16'd0;
              nxt.phase      = PH_S_DATA;
            end
          end
          PH_S_DATA: begin
            nxt.byte_count = count_inc;
            if (count_inc == cur.xfer_len) begin
              fin    = 1'b1;
              fin_st = ST_DONE;
            end else begin
              nxt.pin     = tx_byte;
              res.tx_take = 1'b1;
              nxt.pout    = !cur.pout;
            end
          end
          PH_R_CMD: begin
            nxt.drive = 1'b0;
            nxt.pin   = 8'd0;
            nxt.pout  = 1'b1;
            nxt.phase = PH_R_HI;
          end
          PH_R_HI: begin
            nxt.xfer_len = {data_in, 8'd0};
            nxt.pout     = 1'b0;
            nxt.phase    = PH_R_LO;
          end
          PH_R_LO: begin
            nxt.xfer_len = rx_len;
            if (rx_len == 16'd0) begin
              fin    = 1'b1;
              fin_st = ST_DONE;
            end else begin
              nxt.pout       = 1'b1;
              nxt.byte_count = 16'd0;
              nxt.phase      = PH_R_DATA;
            end
          end
          PH_R_DATA: begin
            res.rx_byte    = data_in;
            res.rx_valid   = 1'b1;
            nxt.byte_count = count_inc;
            if (count_inc == cur.xfer_len) begin
              res.rx_last = 1'b1;
              fin         = 1'b1;
              fin_st      = ST_DONE;
            end else begin
              nxt.pout = !cur.pout;
            end
          end
          default: begin
            fin    = 1'b1;
            fin_st = ST_IDLE;
          end
        endcase
      end
    end

    // Drop all pins and return to idle at the end of a transfer
    if (fin) begin
      nxt.pin         = 8'd0;
      nxt.drive       = 1'b0;
      nxt.sel         = 1'b0;
      nxt.pout        = 1'b0;
      nxt.phase       = PH_IDLE;
      nxt.wait_count  = 16'd0;
      nxt.last_status = fin_st;
    end

    // Report pin levels after this tick's update
    res.data_out    = nxt.pin;
    res.data_drive  = nxt.drive;
    res.sel_out     = nxt.sel;
    res.pout_out    = nxt.pout;
    res.recv_length = nxt.rx_mode ? nxt.xfer_len : 16'd0;
    res.status      = nxt.last_status;
  end

endmodule

FILE: rtl/parallel_port_handshake_master_top.sv
// Top level of the parallel-port handshake master: stream ports, APB registers, pipeline.
// Pipeline: an accepted beat passes through the input register, then the result register
// (result register loaded together with the updated transfer state).
// Throughput: one beat per cycle while m_tready does not stall the result register.
// Reset (rst, synchronous): pipeline empty, transfer idle, pins low, status idle,
// timeout_ticks 10000, send_stops_on_timeout 0.
module parallel_port_handshake_master_top (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // length[15:0], tx_byte[23:16], busy_in[24], data_in[32:25], zero[39:33]
  input  logic [39:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_tuser,
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // data_out[7:0], data_drive[8], sel_out[9], pout_out[10], rx_byte[18:11],
  // rx_valid[19], tx_take[20], recv_length[36:21], status[38:37], zero[39]
  output logic [39:0] m_tdata,
  // rx_last
  output logic        m_tlast
);
  import pphm_pkg::*;

  logic [15:0] timeout_ticks;
  logic        send_stops_on_timeout;
  logic        cfg_wr;

  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [39:0] s1_data;
  logic        s2_load;

  xfer_state_t state;
  xfer_state_t state_next;
  result_t     res_next;
  result_t     res;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks         <= TIMEOUT_RESET;
      send_stops_on_timeout <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TIMEOUT) begin
        timeout_ticks <= pwdata[15:0];
      end else begin
        send_stops_on_timeout <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_TIMEOUT) begin
      prdata = {16'd0, timeout_ticks};
    end else begin
      prdata = {31'd0, send_stops_on_timeout};
    end
  end

  // Pipeline control: result register frees up when empty or taken
  assign s2_load  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s2_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_op   <= s_tuser;
      s1_data <= s_tdata;
    end
  end

  pphm_step u_step (
    .cur                   (state),
    .opcode                (s1_op),
    .length                (s1_data[15:0]),
    .tx_byte               (s1_data[23:16]),
    .busy_in               (s1_data[24]),
    .data_in               (s1_data[32:25]),
    .timeout_ticks         (timeout_ticks),
    .send_stops_on_timeout (send_stops_on_timeout),
    .nxt                   (state_next),
    .res                   (res_next)
  );

  // Transfer state advances with each beat moved into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_IDLE;
      state.pout        <= 1'b0;
      state.sel         <= 1'b0;
      state.drive       <= 1'b0;
      state.pin         <= 8'd0;
      state.byte_count  <= 16'd0;
      state.xfer_len    <= 16'd0;
      state.wait_count  <= 16'd0;
      state.last_status <= ST_IDLE;
      state.rx_mode     <= 1'b0;
    end else if (s2_load) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      res <= res_next;
    end
  end

  assign m_tdata = {1'b0, res.status, res.recv_length, res.tx_take, res.rx_valid,
                    res.rx_byte, res.pout_out, res.sel_out, res.data_drive, res.data_out};
  assign m_tlast = res.rx_last;

  // Idle transfer leaves every pin low and released
  a_idle_pins_low: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_IDLE |-> !state.drive && !state.sel && !state.pout && state.pin == 8'd0)
    else $error("idle transfer with pins not low");

  // Bus released once the receive command is acknowledged
  a_rx_released: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_R_HI || state.phase == PH_R_LO || state.phase == PH_R_DATA)
      |-> !state.drive && state.rx_mode)
    else $error("receive phase with data pins driven");

  // Final received byte is always a received byte
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> res.rx_valid)
    else $error("rx_last without rx_valid");

  // Never take a send byte and deliver a received byte together
  a_tx_rx_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.tx_take && res.rx_valid))
    else $error("tx_take and rx_valid together");

  // Stalled input register keeps its beat
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_load |=> s1_valid && $stable(s1_data) && $stable(s1_op))
    else $error("input register lost a stalled beat");

endmodule
